// ===== rtl/core/sfc_pkg.sv =====
// sfc_pkg: constants, beat and result types and the fnv-1a step shared by the
// snapshot frame checker modules. No dependencies.
`timescale 1ns / 1ps

package sfc_pkg;

  localparam int unsigned SFC_MAX_ENTITIES = 256;

  localparam logic [15:0] MAX_FRAME_RESET = 16'hFFFF;
  localparam logic [31:0] FRAME_MAGIC     = 32'h3153_5052;
  localparam logic [63:0] FRAME_VERSION   = 64'd1;
  localparam logic [63:0] FNV_BASIS       = 64'h1465_0FB0_739D_0383;

  // header layout, offsets of the last byte of each field
  localparam logic [15:0] HDR_BYTES   = 16'd24;
  localparam logic [15:0] OFF_MAGIC   = 16'd3;
  localparam logic [15:0] OFF_VERSION = 16'd5;
  localparam logic [15:0] OFF_SEQ     = 16'd13;
  localparam logic [15:0] OFF_TICK    = 16'd21;
  localparam logic [15:0] OFF_COUNT   = 16'd23;
  localparam logic [15:0] REC_BYTES   = 16'd52;
  localparam logic [5:0]  REC_LAST    = 6'd51;

  localparam logic [3:0] TAG_SEQUENCE = 4'd0;
  localparam logic [3:0] TAG_TICK     = 4'd1;
  localparam logic [3:0] TAG_COUNT    = 4'd2;
  localparam logic [3:0] TAG_ID       = 4'd3;
  localparam logic [3:0] TAG_CHECKSUM = 4'd15;

  localparam logic [3:0] FP_ID       = 4'd0;
  localparam logic [3:0] FP_OWNER    = 4'd1;
  localparam logic [3:0] FP_REVISION = 4'd2;
  localparam logic [3:0] FP_XFORM    = 4'd3;
  localparam logic [3:0] FP_SCALE    = 4'd9;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } beat_t;

  typedef struct packed {
    logic [3:0]  field_tag;
    logic [63:0] field_value;
    logic [9:0]  entity_index;
    logic        frame_done;
    logic        status;
  } res_t;

  // (h ^ b) * 0x100000001b3 mod 2^64, as shifts and adds
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8);
  endfunction

endpackage

// ===== rtl/core/sfc_byte_if.sv =====
// sfc_byte_if: valid/ready channel that carries one frame byte per beat.
// Uses nothing but its own signals.
`timescale 1ns / 1ps

interface sfc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

// ===== rtl/core/sfc_field_if.sv =====
// sfc_field_if: valid/ready channel that carries one decoded field or frame
// status per beat. Uses nothing but its own signals.
`timescale 1ns / 1ps

interface sfc_field_if;
  logic        valid;
  logic        ready;
  logic [3:0]  field_tag;
  logic [63:0] field_value;
  logic [9:0]  entity_index;
  logic        frame_done;
  logic        status;

  modport source (output valid, output field_tag, output field_value,
                  output entity_index, output frame_done, output status, input ready);
  modport sink   (input valid, input field_tag, input field_value,
                  input entity_index, input frame_done, input status, output ready);
endinterface

// ===== rtl/core/sfc_in_reg.sv =====
// sfc_in_reg: input register of the checker, holds one byte beat until the
// decoder takes it. Depends on sfc_pkg and sfc_byte_if.
`timescale 1ns / 1ps

module sfc_in_reg import sfc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  sfc_byte_if.sink     byte_i,
  input  logic         take_i,
  output logic         valid_o,
  output beat_t        beat_o
);

  logic  valid_q, valid_d;
  beat_t beat_q;
  logic  load;

  assign byte_i.ready = !valid_q || take_i;
  assign load         = byte_i.valid && byte_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q <= '{data_byte: byte_i.data_byte, frame_end: byte_i.frame_end};
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// ===== rtl/core/sfc_frame_decode.sv =====
// sfc_frame_decode: frame state, running fnv-1a hash, field assembly and the
// corruption checks, one byte per step. Depends on sfc_pkg.
`timescale 1ns / 1ps

module sfc_frame_decode import sfc_pkg::*; #(
  parameter int unsigned MaxEntities = SFC_MAX_ENTITIES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        step_i,
  input  beat_t       beat_i,
  output logic        has_res_o,
  output res_t        res_o
);

  logic [15:0] max_q;
  logic [15:0] off_q, off_d;
  logic [63:0] shift_q, shift_d;
  logic [2:0]  lane_q, lane_d;
  logic [63:0] hash_q, hash_d;
  logic [15:0] base_q, base_d;
  logic [5:0]  recw_q, recw_d;
  logic [9:0]  ent_q, ent_d;
  logic [31:0] prev_q, prev_d;
  logic        corrupt_q, corrupt_d;

  always_comb begin
    logic [16:0] len;
    logic [16:0] chk_end;
    logic [63:0] acc;
    logic [3:0]  fp;
    logic        corrupt;
    logic        done;
    logic        emit;
    logic        last_chk;

    off_d   = off_q;
    shift_d = shift_q;
    lane_d  = lane_q;
    hash_d  = hash_q;
    base_d  = base_q;
    recw_d  = recw_q;
    ent_d   = ent_q;
    prev_d  = prev_q;
    res_o   = '0;
    fp      = FP_ID;
    done    = 1'b0;
    emit    = 1'b0;

    acc      = shift_q | ({56'd0, beat_i.data_byte} << {lane_q, 3'b000});
    len      = {1'b0, off_q} + 17'd1;
    chk_end  = {1'b0, base_q} + 17'd8;
    last_chk = ({1'b0, off_q} == chk_end - 17'd1);
    corrupt  = corrupt_q || (len > {1'b0, max_q});

    if (!corrupt) begin
      if (off_q < HDR_BYTES) begin
        hash_d  = fnv_step(hash_q, beat_i.data_byte);
        shift_d = acc;
        lane_d  = lane_q + 3'd1;
        if (off_q == OFF_MAGIC) begin
          done = 1'b1;
          if (acc != {32'd0, FRAME_MAGIC}) corrupt = 1'b1;
        end else if (off_q == OFF_VERSION) begin
          done = 1'b1;
          if (acc != FRAME_VERSION) corrupt = 1'b1;
        end else if (off_q == OFF_SEQ) begin
          done = 1'b1;
          emit = 1'b1;
          res_o.field_tag = TAG_SEQUENCE;
          if (acc == 64'd0) corrupt = 1'b1;
        end else if (off_q == OFF_TICK) begin
          done = 1'b1;
          emit = 1'b1;
          res_o.field_tag = TAG_TICK;
        end else if (off_q == OFF_COUNT) begin
          done = 1'b1;
          emit = 1'b1;
          res_o.field_tag = TAG_COUNT;
          if (acc > 64'(MaxEntities)) begin
            corrupt = 1'b1;
          end else begin
            base_d = HDR_BYTES + {5'd0, acc[10:0]} * REC_BYTES;
          end
        end
      end else if (off_q < base_q) begin
        hash_d  = fnv_step(hash_q, beat_i.data_byte);
        shift_d = acc;
        lane_d  = lane_q + 3'd1;
        if (recw_q < 6'd4) begin
          fp = FP_ID;
        end else if (recw_q < 6'd8) begin
          fp = FP_OWNER;
        end else if (recw_q < 6'd16) begin
          fp = FP_REVISION;
        end else begin
          fp = FP_XFORM + (recw_q[5:2] - 4'd4);
        end
        done = (recw_q == 6'd3) || (recw_q == 6'd7) || (recw_q == 6'd15) ||
               ((recw_q >= 6'd16) && (recw_q[1:0] == 2'b11));
        recw_d = (recw_q == REC_LAST) ? 6'd0 : recw_q + 6'd1;
        ent_d  = (recw_q == REC_LAST) ? ent_q + 10'd1 : ent_q;
        if (done) begin
          emit = 1'b1;
          res_o.field_tag    = TAG_ID + fp;
          res_o.entity_index = ent_q;
          if (fp == FP_ID) begin
            if (acc == 64'd0 || acc <= {32'd0, prev_q}) corrupt = 1'b1;
            prev_d = acc[31:0];
          end else if (fp >= FP_XFORM) begin
            if (acc[30:23] == 8'hFF) corrupt = 1'b1;
            // scale words must be strictly positive
            if (fp >= FP_SCALE && (acc[31] || acc == 64'd0)) corrupt = 1'b1;
          end
        end
      end else if ({1'b0, off_q} < chk_end) begin
        shift_d = acc;
        lane_d  = lane_q + 3'd1;
        if (last_chk) begin
          done = 1'b1;
          emit = 1'b1;
          res_o.field_tag = TAG_CHECKSUM;
          if (acc != hash_q) corrupt = 1'b1;
        end
      end else begin
        corrupt = 1'b1;
      end
    end

    if (done) begin
      shift_d = '0;
      lane_d  = '0;
    end
    if (emit) begin
      res_o.field_value = acc;
    end

    corrupt_d = corrupt;
    off_d     = len[16] ? 16'hFFFF : len[15:0];

    res_o.frame_done = beat_i.frame_end;
    res_o.status     = beat_i.frame_end && !(!corrupt && last_chk);
    has_res_o        = emit || beat_i.frame_end;

    if (beat_i.frame_end) begin
      off_d     = '0;
      shift_d   = '0;
      lane_d    = '0;
      hash_d    = FNV_BASIS;
      base_d    = HDR_BYTES;
      recw_d    = '0;
      ent_d     = '0;
      prev_d    = '0;
      corrupt_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q     <= MAX_FRAME_RESET;
      off_q     <= '0;
      shift_q   <= '0;
      lane_q    <= '0;
      hash_q    <= FNV_BASIS;
      base_q    <= HDR_BYTES;
      recw_q    <= '0;
      ent_q     <= '0;
      prev_q    <= '0;
      corrupt_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (step_i) begin
        off_q     <= off_d;
        shift_q   <= shift_d;
        lane_q    <= lane_d;
        hash_q    <= hash_d;
        base_q    <= base_d;
        recw_q    <= recw_d;
        ent_q     <= ent_d;
        prev_q    <= prev_d;
        corrupt_q <= corrupt_d;
      end
    end
  end

endmodule

// ===== rtl/core/sfc_out_reg.sv =====
// sfc_out_reg: result register that drives the field channel and holds a beat
// while the receiver stalls. Depends on sfc_pkg and sfc_field_if.
`timescale 1ns / 1ps

module sfc_out_reg import sfc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  res_t         res_i,
  output logic         free_o,
  sfc_field_if.source  field_o
);

  logic valid_q, valid_d;
  res_t res_q;

  assign free_o = !valid_q || field_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (field_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign field_o.valid        = valid_q;
  assign field_o.field_tag    = res_q.field_tag;
  assign field_o.field_value  = res_q.field_value;
  assign field_o.entity_index = res_q.entity_index;
  assign field_o.frame_done   = res_q.frame_done;
  assign field_o.status       = res_q.status;

endmodule

// ===== rtl/core/snapshot_frame_checker_core.sv =====
// snapshot_frame_checker_core: top level of the snapshot frame checker.
// Depends on sfc_pkg, sfc_byte_if, sfc_field_if, sfc_in_reg, sfc_frame_decode
// and sfc_out_reg.
//
// Usage:
//   byte_i carries one frame byte per beat, frame_end high on the last byte.
//   field_o gives one beat per field completed while the frame is sound
//   (sequence, tick, count, record fields, checksum); the last byte's beat
//   has frame_done, status 0 ok or 1 corrupt. Magic, version checked only.
//   cfg_we_i / cfg_wdata_i write max_frame_bytes; write only while idle.
// Timing:
//   a byte accepted on byte_i is decoded out of the input register and its
//   result is registered in the output register that drives field_o.
//   one byte per cycle sustained unless a byte with a result waits on a
//   stalled field_o; the decoder updates its hash and field state per byte.
// Reset:
//   clears both channel valid flags and the frame state; max_frame_bytes
//   returns to 65535. No clearing pass, ready right after reset.
// Stall:
//   while a result waits on field_o, bytes that make no result still go
//   through; a byte with a result waits in the input register, and then
//   byte_i.ready drops until the receiver takes the pending beat.
`timescale 1ns / 1ps

module snapshot_frame_checker_core import sfc_pkg::*; #(
  parameter int unsigned MaxEntities = SFC_MAX_ENTITIES
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  sfc_byte_if.sink     byte_i,
  sfc_field_if.source  field_o
);

  logic  in_valid;
  beat_t in_beat;
  logic  has_res;
  res_t  res;
  logic  out_free;
  logic  take;

  // a byte with no result never needs the output slot
  assign take = in_valid && (out_free || !has_res);

  sfc_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_i),
    .take_i  (take),
    .valid_o (in_valid),
    .beat_o  (in_beat)
  );

  sfc_frame_decode #(
    .MaxEntities (MaxEntities)
  ) u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (take),
    .beat_i      (in_beat),
    .has_res_o   (has_res),
    .res_o       (res)
  );

  sfc_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (take && has_res),
    .res_i   (res),
    .free_o  (out_free),
    .field_o (field_o)
  );

endmodule

// ===== tb/tb_snapshot_frame_checker_core.sv =====
// tb_snapshot_frame_checker_core: self-checking bench for the snapshot frame checker;
// builds good and damaged frames, predicts every field beat and the frame status.
// Depends on sfc_pkg, sfc_byte_if, sfc_field_if and snapshot_frame_checker_core.
`timescale 1ns / 1ps

module tb_snapshot_frame_checker_core;
  import sfc_pkg::*;

  localparam logic [63:0] FNV_PRIME_64 = 64'h0000_0100_0000_01B3;
  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD   = 300;
  localparam int MAX_GAP     = 12;

  typedef enum int {
    FLAW_NONE, FLAW_MAGIC, FLAW_VERSION, FLAW_SEQ_ZERO, FLAW_COUNT_OVER,
    FLAW_ID_ZERO, FLAW_ID_ORDER, FLAW_NAN, FLAW_SCALE_NEG, FLAW_SCALE_ZERO,
    FLAW_SHORT, FLAW_LONG, FLAW_HASH
  } flaw_e;

  typedef struct {
    logic [7:0] data;
    logic       last;
    int         gap;
  } byte_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  sfc_byte_if  byte_if ();
  sfc_field_if field_if ();

  snapshot_frame_checker_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .byte_i     (byte_if),
    .field_o    (field_if)
  );

  // frame decoder state, mirrored beat by beat
  logic [15:0] max_len;
  logic [15:0] cur_off;
  logic [63:0] shift_acc;
  logic [63:0] hash_acc;
  logic [10:0] n_ents;
  logic [10:0] ent_no;
  logic [31:0] last_id;
  bit          bad;

  byte_item_t  byte_feed[$];
  res_t        field_expect[$];
  int          fed_total;
  int          in_beats;
  int          field_beats;
  int          errors;
  int          stall_cycles;
  bit          tx_gappy;
  bit          rx_gappy;
  int          hold_reqs;

  // driver and receiver private state
  byte_item_t  tx_cur;
  bit          tx_loaded;
  int          tx_wait;
  int          tx_seen;
  logic        tx_valid;
  int          rx_wait;
  int          rx_seen;
  int          hold_done;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void frame_restart();
    cur_off   = '0;
    shift_acc = '0;
    hash_acc  = FNV_BASIS;
    n_ents    = '0;
    ent_no    = '0;
    last_id   = '0;
    bad       = 1'b0;
  endfunction

  // returns 1 when the beat produces a field or status beat
  function automatic bit decode_beat(input logic [7:0] b, input logic last, output res_t res);
    int unsigned off, len, base, start, roff, wpos, fp, fin;
    bit          emit;
    logic [3:0]  tag;
    logic [63:0] val;
    logic [9:0]  idx;
    off  = 32'(cur_off);
    len  = off + 1;
    base = 32'(HDR_BYTES) + 32'(REC_BYTES) * 32'(n_ents);
    emit = 1'b0;
    tag  = '0;
    val  = '0;
    idx  = '0;
    res  = '0;
    if (len > 32'(max_len)) bad = 1'b1;
    if (!bad) begin
      if (off < 32'(HDR_BYTES)) begin
        hash_acc = (hash_acc ^ 64'(b)) * FNV_PRIME_64;
        if (off <= 32'(OFF_MAGIC)) start = 0;
        else if (off <= 32'(OFF_VERSION)) start = 32'(OFF_MAGIC) + 1;
        else if (off <= 32'(OFF_SEQ)) start = 32'(OFF_VERSION) + 1;
        else if (off <= 32'(OFF_TICK)) start = 32'(OFF_SEQ) + 1;
        else start = 32'(OFF_TICK) + 1;
        shift_acc |= 64'(b) << (8 * (off - start));
        if (off inside {OFF_MAGIC, OFF_VERSION, OFF_SEQ, OFF_TICK, OFF_COUNT}) begin
          val = shift_acc;
          shift_acc = '0;
          case (off)
            OFF_MAGIC: if (val != 64'(FRAME_MAGIC)) bad = 1'b1;
            OFF_VERSION: if (val != FRAME_VERSION) bad = 1'b1;
            OFF_SEQ: begin
              emit = 1'b1;
              tag  = TAG_SEQUENCE;
              if (val == '0) bad = 1'b1;
            end
            OFF_TICK: begin
              emit = 1'b1;
              tag  = TAG_TICK;
            end
            default: begin
              emit = 1'b1;
              tag  = TAG_COUNT;
              if (val > 64'(SFC_MAX_ENTITIES)) bad = 1'b1;
              else n_ents = val[10:0];
            end
          endcase
        end
      end else if (off < base) begin
        hash_acc = (hash_acc ^ 64'(b)) * FNV_PRIME_64;
        roff   = off - 32'(HDR_BYTES);
        wpos   = roff % 32'(REC_BYTES);
        ent_no = 11'(roff / 32'(REC_BYTES));
        if (wpos < 4) begin
          fp = 32'(FP_ID);
          start = 0;
        end else if (wpos < 8) begin
          fp = 32'(FP_OWNER);
          start = 4;
        end else if (wpos < 16) begin
          fp = 32'(FP_REVISION);
          start = 8;
        end else begin
          fp = 32'(FP_XFORM) + (wpos - 16) / 4;
          start = 16 + 4 * (fp - 32'(FP_XFORM));
        end
        fin = start + ((fp == 32'(FP_REVISION)) ? 7 : 3);
        shift_acc |= 64'(b) << (8 * (wpos - start));
        if (wpos == fin) begin
          val = shift_acc;
          shift_acc = '0;
          emit = 1'b1;
          tag  = TAG_ID + 4'(fp);
          idx  = ent_no[9:0];
          if (fp == 32'(FP_ID)) begin
            if (val == '0 || val <= 64'(last_id)) bad = 1'b1;
            last_id = val[31:0];
          end else if (fp >= 32'(FP_XFORM)) begin
            // all-ones exponent is inf or nan
            if (val[30:23] == 8'hFF) bad = 1'b1;
            if (fp >= 32'(FP_SCALE) && (val[31] || val == '0)) bad = 1'b1;
          end
        end
      end else if (off < base + 8) begin
        shift_acc |= 64'(b) << (8 * (off - base));
        if (off == base + 7) begin
          val = shift_acc;
          shift_acc = '0;
          emit = 1'b1;
          tag  = TAG_CHECKSUM;
          if (val != hash_acc) bad = 1'b1;
        end
      end else begin
        bad = 1'b1;
      end
    end
    cur_off = (len > 65535) ? 16'hFFFF : len[15:0];
    if (emit) begin
      res.field_tag    = tag;
      res.field_value  = val;
      res.entity_index = idx;
    end
    if (last) begin
      res.frame_done = 1'b1;
      res.status     = !(!bad && off == base + 7);
      frame_restart();
      return 1'b1;
    end
    return emit;
  endfunction

  // sample both channels, check results, predict accepted bytes
  always @(posedge clk_i) begin
    res_t got, want, fresh;
    bit   moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (field_if.valid && field_if.ready) begin
        moved = 1'b1;
        field_beats++;
        got = '{field_if.field_tag, field_if.field_value, field_if.entity_index,
                field_if.frame_done, field_if.status};
        if (field_expect.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat tag %0d value %h entity %0d done %0b status %0b",
                   $time, got.field_tag, got.field_value, got.entity_index,
                   got.frame_done, got.status);
        end else begin
          want = field_expect.pop_front();
          if (got !== want) begin
            errors++;
            $display({"%0t: mismatch expected tag %0d value %h entity %0d done %0b ",
                      "status %0b, actual tag %0d value %h entity %0d done %0b status %0b"},
                     $time, want.field_tag, want.field_value, want.entity_index,
                     want.frame_done, want.status, got.field_tag, got.field_value,
                     got.entity_index, got.frame_done, got.status);
          end
        end
      end
      if (byte_if.valid && byte_if.ready) begin
        moved = 1'b1;
        in_beats++;
        if (decode_beat(byte_if.data_byte, byte_if.frame_end, fresh))
          field_expect = {field_expect, fresh};
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, stall_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // byte sender
  always @(negedge clk_i) begin
    if (rst_ni) begin
      tx_valid = byte_if.valid;
      if (tx_valid && in_beats != tx_seen) begin
        tx_seen  = in_beats;
        tx_valid = 1'b0;
      end
      if (!tx_valid) begin
        if (!tx_loaded && byte_feed.size() != 0) begin
          tx_cur    = byte_feed.pop_front();
          tx_wait   = tx_cur.gap;
          tx_loaded = 1'b1;
        end
        if (tx_loaded) begin
          if (tx_wait == 0) begin
            tx_valid  = 1'b1;
            tx_loaded = 1'b0;
          end else begin
            tx_wait--;
          end
        end
      end
      byte_if.valid <= tx_valid;
      if (tx_valid) begin
        byte_if.data_byte <= tx_cur.data;
        byte_if.frame_end <= tx_cur.last;
      end
    end
  end

  // result receiver, long holds applied here
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (field_beats != rx_seen) begin
        rx_seen = field_beats;
        rx_wait = rx_gappy ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (hold_reqs != hold_done) begin
        hold_done = hold_reqs;
        rx_wait   = LONG_HOLD;
      end
      if (rx_wait > 0) begin
        field_if.ready <= 1'b0;
        rx_wait--;
      end else begin
        field_if.ready <= 1'b1;
      end
    end
  end

  task automatic feed(input logic [7:0] fb[$]);
    byte_item_t it;
    for (int k = 0; k < fb.size(); k++) begin
      it.data = fb[k];
      it.last = (k == fb.size() - 1);
      it.gap  = tx_gappy ? $urandom_range(0, MAX_GAP) : 0;
      byte_feed = {byte_feed, it};
    end
    fed_total += fb.size();
  endtask

  task automatic put_le(ref logic [7:0] fb[$], input logic [63:0] v, input int n);
    for (int k = 0; k < n; k++) fb = {fb, v[8*k +: 8]};
  endtask

  function automatic logic [31:0] xform_word(input bit scale);
    logic [31:0] w;
    case ($urandom_range(0, 7))
      0: begin
        w = '0;
        w[31] = 1'($urandom_range(0, 1));
      end
      1: w = 32'h7F7F_FFFF;
      2: w = 32'h0000_0001;
      default: w = $urandom;
    endcase
    if (w[30:23] == 8'hFF) w[23] = 1'b0;
    if (scale) begin
      w[31] = 1'b0;
      if (w == 0) w = 32'h3F80_0000;
    end
    return w;
  endfunction

  task automatic add_frame(input int n_rec, input flaw_e flaw, input bit extremes);
    logic [7:0]  fb[$];
    logic [63:0] seq, tick, sum;
    logic [31:0] magic, id, prev_id, w;
    logic [15:0] ver, cnt;
    int          bad_rec, bad_word, cut;
    if (flaw >= FLAW_ID_ZERO && flaw <= FLAW_SCALE_ZERO && n_rec == 0) n_rec = 1;
    if (flaw == FLAW_ID_ORDER && n_rec < 2) n_rec = 2;
    bad_rec  = (flaw == FLAW_ID_ORDER) ? $urandom_range(1, n_rec - 1)
                                       : $urandom_range(0, (n_rec > 0) ? n_rec - 1 : 0);
    bad_word = (flaw == FLAW_NAN) ? $urandom_range(0, 8) : $urandom_range(6, 8);
    magic = FRAME_MAGIC;
    if (flaw == FLAW_MAGIC) magic ^= 32'd1 << $urandom_range(0, 31);
    ver = 16'd1;
    if (flaw == FLAW_VERSION) begin
      ver = 16'($urandom_range(0, 65535));
      if (ver == 16'd1) ver = '0;
    end
    seq  = extremes ? '1 : {$urandom, $urandom};
    if (seq == 0) seq = 64'd1;
    if (flaw == FLAW_SEQ_ZERO) seq = '0;
    tick = extremes ? '0 : {$urandom, $urandom};
    cnt  = 16'(n_rec);
    if (flaw == FLAW_COUNT_OVER) cnt = 16'($urandom_range(SFC_MAX_ENTITIES + 1, 65535));
    put_le(fb, 64'(magic), 4);
    put_le(fb, 64'(ver), 2);
    put_le(fb, seq, 8);
    put_le(fb, tick, 8);
    put_le(fb, 64'(cnt), 2);
    prev_id = '0;
    id = extremes ? 32'hFFFF_FFFF - 32'(n_rec) + 32'd1 : $urandom_range(1, 1000);
    for (int k = 0; k < n_rec; k++) begin
      if (k > 0) id = extremes ? id + 32'd1 : id + $urandom_range(1, 5000);
      w = id;
      if (k == bad_rec && flaw == FLAW_ID_ZERO) w = '0;
      if (k == bad_rec && flaw == FLAW_ID_ORDER) w = prev_id - $urandom_range(0, 1);
      put_le(fb, 64'(w), 4);
      prev_id = w;
      put_le(fb, 64'($urandom), 4);
      put_le(fb, {$urandom, $urandom}, 8);
      for (int t = 0; t < 9; t++) begin
        w = xform_word(t >= 6);
        if (k == bad_rec && t == bad_word) begin
          if (flaw == FLAW_NAN) w[30:23] = 8'hFF;
          if (flaw == FLAW_SCALE_NEG) w[31] = 1'b1;
          if (flaw == FLAW_SCALE_ZERO) begin
            w = '0;
            w[31] = 1'($urandom_range(0, 1));
          end
        end
        put_le(fb, 64'(w), 4);
      end
    end
    sum = FNV_BASIS;
    for (int k = 0; k < fb.size(); k++) sum = (sum ^ 64'(fb[k])) * FNV_PRIME_64;
    if (flaw == FLAW_HASH) sum ^= 64'd1 << $urandom_range(0, 63);
    put_le(fb, sum, 8);
    if (flaw == FLAW_SHORT) begin
      cut = $urandom_range(1, fb.size() - 1);
      repeat (cut) void'(fb.pop_back());
    end
    if (flaw == FLAW_LONG) repeat ($urandom_range(1, 4)) fb = {fb, 8'($urandom)};
    feed(fb);
  endtask

  task automatic noise_frame(input int len);
    logic [7:0] fb[$];
    repeat (len) fb = {fb, 8'($urandom)};
    feed(fb);
  endtask

  task automatic random_frames(input int target);
    int first, pick, n_rec;
    first = fed_total;
    while (fed_total - first < target) begin
      tx_gappy = ($urandom_range(0, 3) != 0);
      rx_gappy = ($urandom_range(0, 3) != 0);
      pick  = $urandom_range(0, 99);
      n_rec = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
      if (pick < 60) add_frame(n_rec, FLAW_NONE, 1'b0);
      else if (pick < 90)
        add_frame(n_rec, flaw_e'($urandom_range(int'(FLAW_MAGIC), int'(FLAW_HASH))), 1'b0);
      else noise_frame($urandom_range(1, 80));
    end
  endtask

  task automatic wait_drained();
    while (in_beats != fed_total || field_expect.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_max_len(input logic [15:0] v);
    wait_drained();
    // bytes with no result may still sit in the pipe
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    max_len = v;
  endtask

  initial begin
    byte_if.valid     = 1'b0;
    byte_if.data_byte = '0;
    byte_if.frame_end = 1'b0;
    field_if.ready    = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    rst_ni            = 1'b0;
    max_len           = MAX_FRAME_RESET;
    frame_restart();
    tx_gappy = 1'b1;
    rx_gappy = 1'b1;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed frames at the reset length limit
    add_frame(2, FLAW_NONE, 1'b1);
    for (int f = int'(FLAW_MAGIC); f <= int'(FLAW_HASH); f++) add_frame(0, flaw_e'(f), 1'b0);
    noise_frame(1);
    noise_frame(20);

    set_max_len(16'd32);
    add_frame(0, FLAW_NONE, 1'b0);
    add_frame(1, FLAW_NONE, 1'b0);

    set_max_len(16'($urandom_range(60, 700)));
    random_frames(100);
    hold_reqs++;

    set_max_len(16'hFFFF);
    random_frames(50);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/sfc_pkg.sv
rtl/core/sfc_byte_if.sv
rtl/core/sfc_field_if.sv
rtl/core/sfc_in_reg.sv
rtl/core/sfc_frame_decode.sv
rtl/core/sfc_out_reg.sv
rtl/core/snapshot_frame_checker_core.sv
tb/tb_snapshot_frame_checker_core.sv
